// ----- sv/whlr_pkg.sv -----
package whlr_pkg;

    // input item kinds
    localparam logic [1:0] KIND_PACKET = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_BUTTON = 2'd2;

    // packet message types
    localparam logic [2:0] MSG_PAIR_REQ = 3'd0;
    localparam logic [2:0] MSG_KEYBOARD = 3'd1;
    localparam logic [2:0] MSG_MOUSE    = 3'd2;
    localparam logic [2:0] MSG_CONSUMER = 3'd3;
    localparam logic [2:0] MSG_PING     = 3'd4;

    // link states
    localparam logic [1:0] ST_UNPAIRED  = 2'd0;
    localparam logic [1:0] ST_PAIRING   = 2'd1;
    localparam logic [1:0] ST_SCANNING  = 2'd2;
    localparam logic [1:0] ST_CONNECTED = 2'd3;

    // led modes
    localparam logic [2:0] LED_OFF  = 3'd0;
    localparam logic [2:0] LED_ON   = 3'd1;
    localparam logic [2:0] LED_SLOW = 3'd2;
    localparam logic [2:0] LED_FAST = 3'd3;
    localparam logic [2:0] LED_ONCE = 3'd4;

    // reply kinds
    localparam logic [1:0] TX_NONE = 2'd0;
    localparam logic [1:0] TX_ACK  = 2'd1;
    localparam logic [1:0] TX_PAIR = 2'd2;
    localparam logic [1:0] TX_PONG = 2'd3;

    // report kinds
    localparam logic [1:0] RPT_NONE     = 2'd0;
    localparam logic [1:0] RPT_KEYBOARD = 2'd1;
    localparam logic [1:0] RPT_MOUSE    = 2'd2;
    localparam logic [1:0] RPT_CONSUMER = 2'd3;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_OWN_ID       = 2'd0;
    localparam logic [1:0] REG_PAIR_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_CHECK_PERIOD = 2'd2;
    localparam logic [1:0] REG_LINK_TIMEOUT = 2'd3;

    localparam logic [7:0]  ADDR_PREFIX      = 8'hD0;
    localparam logic [7:0]  PONG_BATTERY     = 8'hFF;
    localparam logic [7:0]  PREV_SEQ_RESET   = 8'hFF;
    localparam logic [15:0] PAIR_TIMEOUT_DEF = 16'd30000;
    localparam logic [15:0] CHECK_PERIOD_DEF = 16'd1000;
    localparam logic [15:0] LINK_TIMEOUT_DEF = 16'd2000;
    localparam logic [15:0] CNT_MAX          = 16'hFFFF;
    localparam logic [16:0] SINCE_MAX        = 17'h1FFFF;

    typedef struct packed {
        logic [1:0]  tx_kind;
        logic [7:0]  tx_seq;
        logic [7:0]  tx_leds;
        logic [31:0] pair_address;
        logic [1:0]  report_kind;
        logic [63:0] report_data;
        logic [1:0]  link_state;
        logic        is_connected;
        logic        is_paired;
        logic [2:0]  led_pattern;
    } t_result;

endpackage

// ----- sv/wireless_hid_link_receiver_core.sv -----
// channel   | valid        | ready        | beat contents
// ----------+--------------+--------------+--------------------------------------------
// item in   | i_in_valid   | o_in_ready   | kind, pkt_type, seq, peer_address, buttons,
//           |              |              | payload, host_leds, button_down
// result    | o_out_valid  | i_out_ready  | reply, new report, link status, led mode
// config    | psel/penable | pready (=1)  | apb write/read of the four registers
//
// one item per cycle unless a waiting result is not taken: the link state is updated and the
// result register loaded in the same edge that accepts the beat, so a result appears in the cycle after acceptance
// the result register is the only stage; o_in_ready stays high while it is empty or
// being drained, so a waiting result does not stop the next beat if it is taken
// synchronous active-low reset puts the link in unpaired with slow blink and restores
// the register defaults; no clearing pass is needed
module wireless_hid_link_receiver_core
    import whlr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // item in
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_pkt_type,
    input  logic [7:0]  i_seq,
    input  logic [31:0] i_peer_address,
    input  logic [7:0]  i_modifier_or_buttons,
    input  logic [47:0] i_payload,
    input  logic [7:0]  i_host_leds,
    input  logic        i_button_down,

    // result out
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_tx_kind,
    output logic [7:0]  o_tx_seq,
    output logic [7:0]  o_tx_leds,
    output logic [31:0] o_pair_address,
    output logic [1:0]  o_report_kind,
    output logic [63:0] o_report_data,
    output logic [1:0]  o_link_state,
    output logic        o_is_connected,
    output logic        o_is_paired,
    output logic [2:0]  o_led_pattern,

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [23:0] r_own_id;
    logic [15:0] r_pair_timeout;
    logic [15:0] r_check_period;
    logic [15:0] r_link_timeout;

    // link state; the peer address of a pairing request is not kept since
    // nothing in this block reads it back
    logic [1:0]  r_link, n_link;
    logic        r_paired, n_paired;
    logic        r_conn, n_conn;
    logic [7:0]  r_prev_seq, n_prev_seq;
    logic [16:0] r_since, n_since;
    logic [15:0] r_check_cnt, n_check_cnt;
    logic [15:0] r_pair_cnt, n_pair_cnt;
    logic [2:0]  r_led, n_led;
    logic        r_btn_prev, n_btn_prev;

    // result register
    logic        r_out_valid;
    t_result     r_res, n_res;

    logic        w_accept;
    logic        w_cfg_wr;
    logic        w_go;
    logic [1:0]  w_go_tgt;

    assign pready      = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_cfg_wr    = psel && penable && pwrite && pready;

    // ---------------- apb register file ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id       <= '0;
            r_pair_timeout <= PAIR_TIMEOUT_DEF;
            r_check_period <= CHECK_PERIOD_DEF;
            r_link_timeout <= LINK_TIMEOUT_DEF;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_OWN_ID:       r_own_id       <= pwdata[23:0];
                REG_PAIR_TIMEOUT: r_pair_timeout <= pwdata[15:0];
                REG_CHECK_PERIOD: r_check_period <= pwdata[15:0];
                REG_LINK_TIMEOUT: r_link_timeout <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_OWN_ID:       prdata = {8'h00, r_own_id};
            REG_PAIR_TIMEOUT: prdata = {16'h0000, r_pair_timeout};
            REG_CHECK_PERIOD: prdata = {16'h0000, r_check_period};
            REG_LINK_TIMEOUT: prdata = {16'h0000, r_link_timeout};
        endcase
    end

    // ---------------- per-item decision ----------------
    // first the item's own effects, then at most one state change whose
    // entry actions override led mode and counters
    always_comb begin
        n_link      = r_link;
        n_paired    = r_paired;
        n_conn      = r_conn;
        n_prev_seq  = r_prev_seq;
        n_since     = r_since;
        n_check_cnt = r_check_cnt;
        n_pair_cnt  = r_pair_cnt;
        n_led       = r_led;
        n_btn_prev  = r_btn_prev;
        w_go        = 1'b0;
        w_go_tgt    = r_link;
        n_res       = '0;

        unique case (i_kind)
            KIND_PACKET: begin
                // any packet counts as activity, even one that is dropped
                n_since = '0;
                unique case (i_pkt_type)
                    MSG_PAIR_REQ: begin
                        if (r_link == ST_PAIRING) begin
                            n_res.tx_kind      = TX_PAIR;
                            n_res.pair_address = {ADDR_PREFIX, r_own_id};
                            n_paired           = 1'b1;
                            w_go               = 1'b1;
                            w_go_tgt           = ST_SCANNING;
                        end
                    end
                    MSG_KEYBOARD: begin
                        if (r_link == ST_SCANNING || r_link == ST_CONNECTED) begin
                            if (i_seq != r_prev_seq) begin
                                n_prev_seq        = i_seq;
                                n_res.report_kind = RPT_KEYBOARD;
                                n_res.report_data = {i_payload, 8'h00,
                                                     i_modifier_or_buttons};
                                n_led             = LED_ONCE;
                            end
                            n_res.tx_kind = TX_ACK;
                            n_res.tx_seq  = i_seq;
                            n_res.tx_leds = i_host_leds;
                            w_go          = 1'b1;
                            w_go_tgt      = ST_CONNECTED;
                        end
                    end
                    MSG_MOUSE, MSG_CONSUMER: begin
                        if (r_link == ST_CONNECTED) begin
                            if (i_seq != r_prev_seq) begin
                                n_prev_seq = i_seq;
                                if (i_pkt_type == MSG_MOUSE) begin
                                    n_res.report_kind = RPT_MOUSE;
                                    n_res.report_data = {32'h0, i_payload[23:0],
                                                         i_modifier_or_buttons};
                                end else begin
                                    n_res.report_kind = RPT_CONSUMER;
                                    n_res.report_data = {48'h0, i_payload[15:0]};
                                end
                            end
                            n_res.tx_kind = TX_ACK;
                            n_res.tx_seq  = i_seq;
                            n_res.tx_leds = i_host_leds;
                        end
                    end
                    MSG_PING: begin
                        if (r_link == ST_SCANNING || r_link == ST_CONNECTED) begin
                            n_res.tx_kind = TX_PONG;
                            n_res.tx_leds = PONG_BATTERY;
                            w_go          = 1'b1;
                            w_go_tgt      = ST_CONNECTED;
                        end
                    end
                    default: begin
                        // unknown message types are dropped
                    end
                endcase
            end
            KIND_TICK: begin
                if (r_since != SINCE_MAX) begin
                    n_since = r_since + 17'd1;
                end
                if (r_link == ST_PAIRING) begin
                    if (r_pair_cnt != CNT_MAX) begin
                        n_pair_cnt = r_pair_cnt + 16'd1;
                    end
                    if (n_pair_cnt >= r_pair_timeout) begin
                        w_go     = 1'b1;
                        w_go_tgt = r_paired ? ST_SCANNING : ST_UNPAIRED;
                    end
                end else if (r_link == ST_CONNECTED) begin
                    if (r_check_cnt != CNT_MAX) begin
                        n_check_cnt = r_check_cnt + 16'd1;
                    end
                    if (n_check_cnt >= r_check_period) begin
                        n_check_cnt = '0;
                        if (n_since > {1'b0, r_link_timeout}) begin
                            w_go     = 1'b1;
                            w_go_tgt = ST_SCANNING;
                        end
                    end
                end
            end
            KIND_BUTTON: begin
                // flash-once ends at the next button sample
                if (r_led == LED_ONCE) begin
                    n_led = r_conn ? LED_ON : LED_SLOW;
                end
                if (i_button_down && !r_btn_prev) begin
                    n_btn_prev = 1'b1;
                    w_go       = 1'b1;
                    w_go_tgt   = ST_PAIRING;
                end else if (!i_button_down) begin
                    n_btn_prev = 1'b0;
                end
            end
            default: begin
                // unused kind: status only
            end
        endcase

        // state entry actions; re-entering the current state does nothing
        if (w_go && w_go_tgt != r_link) begin
            n_link = w_go_tgt;
            unique case (w_go_tgt)
                ST_UNPAIRED: begin
                    n_led = LED_SLOW;
                end
                ST_PAIRING: begin
                    n_led      = LED_FAST;
                    n_pair_cnt = '0;
                end
                ST_SCANNING: begin
                    n_led  = LED_SLOW;
                    n_conn = 1'b0;
                end
                ST_CONNECTED: begin
                    n_led       = LED_ON;
                    n_conn      = 1'b1;
                    n_check_cnt = '0;
                end
            endcase
        end

        n_res.link_state   = n_link;
        n_res.is_connected = n_conn;
        n_res.is_paired    = n_paired;
        n_res.led_pattern  = n_led;
    end

    // ---------------- state and result registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link      <= ST_UNPAIRED;
            r_paired    <= 1'b0;
            r_conn      <= 1'b0;
            r_prev_seq  <= PREV_SEQ_RESET;
            r_since     <= '0;
            r_check_cnt <= '0;
            r_pair_cnt  <= '0;
            r_led       <= LED_SLOW;
            r_btn_prev  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_link      <= n_link;
                r_paired    <= n_paired;
                r_conn      <= n_conn;
                r_prev_seq  <= n_prev_seq;
                r_since     <= n_since;
                r_check_cnt <= n_check_cnt;
                r_pair_cnt  <= n_pair_cnt;
                r_led       <= n_led;
                r_btn_prev  <= n_btn_prev;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload holds until the next accepted beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_tx_kind      = r_res.tx_kind;
    assign o_tx_seq       = r_res.tx_seq;
    assign o_tx_leds      = r_res.tx_leds;
    assign o_pair_address = r_res.pair_address;
    assign o_report_kind  = r_res.report_kind;
    assign o_report_data  = r_res.report_data;
    assign o_link_state   = r_res.link_state;
    assign o_is_connected = r_res.is_connected;
    assign o_is_paired    = r_res.is_paired;
    assign o_led_pattern  = r_res.led_pattern;

`ifndef SYNTHESIS
    // connected state always carries the connected flag
    a_conn_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_link_state == ST_CONNECTED |-> o_is_connected)
        else $error("connected state without connected flag");

    // a pairing response marks the link as paired
    a_pair_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_tx_kind == TX_PAIR |-> o_is_paired && o_link_state == ST_SCANNING)
        else $error("pairing response without paired scanning state");

    // every new report is acknowledged
    a_report_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_report_kind != RPT_NONE |-> o_tx_kind == TX_ACK)
        else $error("report without ack");

    // fast blink only while pairing
    a_fast_blink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_led_pattern == LED_FAST |-> o_link_state == ST_PAIRING)
        else $error("fast blink outside pairing");
`endif

endmodule
